// ----- hdl/srp_pkg.sv -----
package srp_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned IndexW  = 3;

  typedef logic [PeriodW-1:0] word_t;
  typedef logic [ShiftW-1:0]  shift_t;
  typedef logic [IndexW-1:0]  index_t;

  // register map
  typedef enum logic [IndexW-1:0] {
    REG_MOVE_PULSES    = 3'd0,
    REG_TARGET_PERIOD  = 3'd1,
    REG_INITIAL_PERIOD = 3'd2,
    REG_MIN_PERIOD     = 3'd3,
    REG_MAX_PERIOD     = 3'd4
  } reg_index_t;

  localparam word_t MovePulsesRst    = 16'd0;
  localparam word_t TargetPeriodRst  = 16'd0;
  localparam word_t InitialPeriodRst = 16'd0;
  localparam word_t MinPeriodRst     = 16'd1;
  localparam word_t MaxPeriodRst     = 16'hFFFF;

  // median of three, well defined for lo > hi
  function automatic word_t median3(word_t a, word_t b, word_t c);
    word_t lo;
    word_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

endpackage

// ----- hdl/srp_cfg_if.sv -----
interface srp_cfg_if;
  logic             valid;
  logic             ready;
  srp_pkg::index_t  index;
  srp_pkg::word_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/srp_pulse_if.sv -----
interface srp_pulse_if;
  logic            valid;
  logic            ready;
  srp_pkg::word_t  pulse_count;

  modport source (output valid, output pulse_count, input ready);
  modport sink (input valid, input pulse_count, output ready);
endinterface

// ----- hdl/srp_period_if.sv -----
interface srp_period_if;
  logic            valid;
  logic            ready;
  srp_pkg::word_t  step_period;
  logic            param_fault;

  modport source (output valid, output step_period, output param_fault, input ready);
  modport sink (input valid, input step_period, input param_fault, output ready);
endinterface

// ----- hdl/stepper_ramp_period.sv -----
// channel  | dir | payload                          | handshake
// ---------+-----+----------------------------------+-------------
// cfg      | in  | index (3b), data (16b)           | valid/ready
// pulse    | in  | pulse_count (16b)                | valid/ready
// period   | out | step_period (16b), param_fault   | valid/ready
//
// One word per cycle while period is ready; four register stages (halving
// count, shift select, shift, clamp), so a word accepted on pulse passes
// through s1, s2, s3 and the output register before it is offered on period.
// cfg is always ready; registers take their listed reset values on rst.
// Each stage holds its word while the stage after it is full and stalled,
// so bubbles close up and nothing is dropped or repeated.
module stepper_ramp_period (
  input  logic               clk,
  input  logic               rst,
  srp_cfg_if.sink            cfg,
  srp_pulse_if.sink          pulse,
  srp_period_if.source       period
);
  import srp_pkg::*;

  typedef struct packed {
    word_t  cnt;
    shift_t pw;
    logic   fault;
  } s1_t;

  typedef struct packed {
    logic   use_target;
    shift_t sh;
    logic   fault;
  } s2_t;

  typedef struct packed {
    word_t  pre;
    logic   fault;
  } s3_t;

  word_t move_pulses;
  word_t target_period;
  word_t initial_period;
  word_t min_period;
  word_t max_period;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_pulses    <= MovePulsesRst;
      target_period  <= TargetPeriodRst;
      initial_period <= InitialPeriodRst;
      min_period     <= MinPeriodRst;
      max_period     <= MaxPeriodRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MOVE_PULSES:    move_pulses    <= cfg.data;
        REG_TARGET_PERIOD:  target_period  <= cfg.data;
        REG_INITIAL_PERIOD: initial_period <= cfg.data;
        REG_MIN_PERIOD:     min_period     <= cfg.data;
        REG_MAX_PERIOD:     max_period     <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  word_t out_period;
  logic  out_fault;
  logic  out_valid;

  assign out_ready   = !out_valid || period.ready;
  assign s3_ready    = !s3_valid || out_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign pulse.ready = s1_ready;

  // halving count: largest k with target << k <= initial, zero if none
  logic [2*PeriodW-1:0] tgt_wide;
  shift_t               pw_next;

  always_comb begin
    tgt_wide = {{PeriodW{1'b0}}, target_period};
    pw_next  = '0;
    for (int k = 0; k < (1 << ShiftW); k++) begin
      if ((tgt_wide << k) <= {{PeriodW{1'b0}}, initial_period}) begin
        pw_next = shift_t'(k);
      end
    end
    s1_next.cnt   = pulse.pulse_count;
    s1_next.pw    = pw_next;
    s1_next.fault = (move_pulses <= word_t'(1))
                    || (target_period < min_period) || (target_period > max_period)
                    || (initial_period < min_period) || (initial_period > max_period);
  end

  // ramp phase and shift select
  word_t half;
  word_t rem;

  always_comb begin
    half       = move_pulses >> 1;
    rem        = move_pulses - s1.cnt;
    s2_next.fault      = s1.fault;
    s2_next.use_target = 1'b1;
    s2_next.sh         = '0;
    if (!s1.fault) begin
      if (s1.cnt <= half) begin
        if (s1.cnt <= {{(PeriodW-ShiftW){1'b0}}, s1.pw}) begin
          s2_next.use_target = 1'b0;
          s2_next.sh         = s1.cnt[ShiftW-1:0];
        end
      end else if (s1.cnt <= move_pulses) begin
        if (rem <= {{(PeriodW-ShiftW){1'b0}}, s1.pw}) begin
          s2_next.use_target = 1'b0;
          s2_next.sh         = rem[ShiftW-1:0];
        end
      end
    end
  end

  // shifted or cruise period
  always_comb begin
    s3_next.fault = s2.fault;
    s3_next.pre   = s2.use_target ? target_period : (initial_period >> s2.sh);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pulse.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pulse.valid) begin
      s1 <= s1_next;
    end
    if (s2_ready && s1_valid) begin
      s2 <= s2_next;
    end
    if (s3_ready && s2_valid) begin
      s3 <= s3_next;
    end
    if (out_ready && s3_valid) begin
      out_period <= median3(s3.pre, min_period, max_period);
      out_fault  <= s3.fault;
    end
  end

  // output word
  assign period.valid       = out_valid;
  assign period.step_period = out_period;
  assign period.param_fault = out_fault;

endmodule
